>>> rtl/lmsfw_pkg.sv
package lmsfw_pkg;

    localparam int BOARD_COUNT       = 4;
    localparam int COLUMNS_PER_BOARD = 48;
    localparam int STORE_DEPTH_DEF   = 256;

    localparam int DATA_BITS    = COLUMNS_PER_BOARD * 8;
    localparam int PREFIX_BITS  = 10;
    localparam int COMMAND_BITS = 12;

    localparam logic [9:0] PREFIX_WORD     = 10'b1010000000;
    localparam logic [7:0] WRAP_LAST_RESET = 8'hFF;

    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_COMMAND = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    typedef enum logic [2:0] {
        KIND_LOAD,
        KIND_COMMAND,
        KIND_REFRESH,
        KIND_CLEAR,
        KIND_TICK,
        KIND_NONE
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  load_address;
        logic [7:0]  load_value;
        logic [11:0] command_word;
        logic [7:0]  start_index;
    } item_t;

    function automatic logic [3:0] board_mask(input logic [1:0] board);
        board_mask = 4'b0001 << board;
    endfunction

endpackage

>>> rtl/lmsfw_front.sv
module lmsfw_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          opcode,
    input  logic [7:0]          load_address,
    input  logic [7:0]          load_value,
    input  logic [11:0]         command_word,
    input  logic [7:0]          start_index,
    output logic                item_valid,
    output lmsfw_pkg::item_t    item,
    input  logic                item_pop
);
    import lmsfw_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      classified;
    logic       push;

    // decode the opcode into an item kind
    always_comb
    begin
        classified.load_address = load_address;
        classified.load_value   = load_value;
        classified.command_word = command_word;
        classified.start_index  = start_index;
        unique case (opcode)
            OP_LOAD:    classified.kind = KIND_LOAD;
            OP_COMMAND: classified.kind = KIND_COMMAND;
            OP_REFRESH: classified.kind = KIND_REFRESH;
            OP_CLEAR:   classified.kind = KIND_CLEAR;
            OP_TICK:    classified.kind = KIND_TICK;
            default:    classified.kind = KIND_NONE;
        endcase
    end

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign item_valid = (count_reg != 2'd0);
    assign item       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ item_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, item_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

>>> rtl/lmsfw_back.sv
module lmsfw_back #(
    parameter int STORE_DEPTH = lmsfw_pkg::STORE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [7:0]          cfg_write_data,
    input  logic                item_valid,
    input  lmsfw_pkg::item_t    item,
    output logic                item_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          chip_selects_n,
    output logic                data_bit,
    output logic                bit_strobe,
    output logic                busy_res,
    output logic                done_res
);
    import lmsfw_pkg::*;

    localparam int         AW        = $clog2(STORE_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(STORE_DEPTH);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_COMMAND,
        MODE_REFRESH,
        MODE_CLEAR
    } mode_t;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_DATA,
        PH_RELEASE
    } phase_t;

    logic [7:0]    store_mem [STORE_DEPTH];
    logic [7:0]    rdata_reg;

    mode_t         mode_reg, mode_next;
    phase_t        phase_reg, phase_next;
    logic [1:0]    board_reg, board_next;
    logic [8:0]    bitcnt_reg, bitcnt_next;
    logic [11:0]   shift_reg, shift_next;
    logic [7:0]    read_index_reg, read_index_next;
    logic [3:0]    sel_reg, sel_next;
    logic [7:0]    wrap_last_reg, wrap_last_next;

    // second stage: control results waiting on the store read
    logic          b_valid_reg;
    logic [3:0]    b_sel_reg;
    logic          b_strobe_reg;
    logic          b_bit_reg;
    logic          b_busy_reg;
    logic          b_done_reg;
    logic          b_ref_reg;
    logic          b_fetch_reg;
    logic [2:0]    b_pos_reg;
    logic [7:0]    byte_reg;

    logic          out_valid_reg;
    logic [3:0]    out_sel_reg;
    logic          out_bit_reg;
    logic          out_strobe_reg;
    logic          out_busy_reg;
    logic          out_done_reg;

    logic          advance;
    logic          fire;
    logic          a_strobe;
    logic          a_bit;
    logic          a_done;
    logic          a_ref;
    logic          a_fetch;
    logic          mem_we;
    logic [7:0]    fetch_idx;
    logic [7:0]    byte_sel;
    logic          b_data;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = item_valid && advance;
    assign item_pop = fire;

    always_comb
    begin
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        board_next      = board_reg;
        bitcnt_next     = bitcnt_reg;
        shift_next      = shift_reg;
        read_index_next = read_index_reg;
        sel_next        = sel_reg;
        wrap_last_next  = cfg_write_en ? cfg_write_data : wrap_last_reg;
        a_strobe        = 1'b0;
        a_bit           = 1'b0;
        a_done          = 1'b0;
        a_ref           = 1'b0;
        a_fetch         = 1'b0;
        mem_we          = 1'b0;
        fetch_idx       = read_index_reg;

        if (fire)
        begin
            unique case (item.kind) inside
                KIND_LOAD:
                begin
                    mem_we = ({1'b0, item.load_address} < DEPTH_LIM);
                end
                KIND_COMMAND, KIND_REFRESH, KIND_CLEAR:
                begin
                    if (mode_reg == MODE_IDLE)
                    begin
                        board_next  = 2'd0;
                        bitcnt_next = 9'd0;
                        phase_next  = PH_HEAD;
                        shift_next  = 12'd0;
                        if (item.kind == KIND_COMMAND)
                        begin
                            mode_next  = MODE_COMMAND;
                            shift_next = item.command_word;
                        end
                        else if (item.kind == KIND_REFRESH)
                        begin
                            mode_next       = MODE_REFRESH;
                            read_index_next = item.start_index;
                        end
                        else
                        begin
                            mode_next = MODE_CLEAR;
                        end
                    end
                end
                KIND_TICK:
                begin
                    if (mode_reg != MODE_IDLE)
                    begin
                        if (phase_reg == PH_RELEASE)
                        begin
                            sel_next = sel_reg | board_mask(board_reg);
                            if (board_reg == 2'(BOARD_COUNT - 1))
                            begin
                                mode_next   = MODE_IDLE;
                                board_next  = 2'd0;
                                bitcnt_next = 9'd0;
                                phase_next  = PH_HEAD;
                                a_done      = 1'b1;
                            end
                            else
                            begin
                                board_next  = board_reg + 2'd1;
                                bitcnt_next = 9'd0;
                                phase_next  = (mode_reg == MODE_CLEAR) ? PH_RELEASE : PH_HEAD;
                            end
                        end
                        else if (mode_reg == MODE_COMMAND)
                        begin
                            sel_next   = sel_reg & ~board_mask(board_reg);
                            a_strobe   = 1'b1;
                            a_bit      = shift_reg[11];
                            shift_next = {shift_reg[10:0], shift_reg[11]};
                            if (bitcnt_reg == 9'(COMMAND_BITS - 1))
                            begin
                                bitcnt_next = 9'd0;
                                phase_next  = PH_RELEASE;
                            end
                            else
                            begin
                                bitcnt_next = bitcnt_reg + 9'd1;
                            end
                        end
                        else if (phase_reg == PH_HEAD)
                        begin
                            sel_next = sel_reg & ~board_mask(board_reg);
                            a_strobe = 1'b1;
                            a_bit    = PREFIX_WORD[4'(PREFIX_BITS - 1) - bitcnt_reg[3:0]];
                            if (bitcnt_reg[3:0] == 4'(PREFIX_BITS - 1))
                            begin
                                bitcnt_next = 9'd0;
                                if (mode_reg == MODE_CLEAR && board_reg != 2'(BOARD_COUNT - 1))
                                begin
                                    board_next = board_reg + 2'd1;
                                end
                                else
                                begin
                                    phase_next = PH_DATA;
                                end
                            end
                            else
                            begin
                                bitcnt_next = {5'd0, bitcnt_reg[3:0] + 4'd1};
                            end
                        end
                        else
                        begin
                            a_strobe = 1'b1;
                            if (mode_reg == MODE_REFRESH)
                            begin
                                a_ref = 1'b1;
                                if (bitcnt_reg[2:0] == 3'd0)
                                begin
                                    a_fetch = 1'b1;
                                    if (read_index_reg > wrap_last_reg
                                        || {1'b0, read_index_reg} >= DEPTH_LIM)
                                    begin
                                        fetch_idx = 8'd0;
                                    end
                                    read_index_next = fetch_idx + 8'd1;
                                end
                            end
                            if (bitcnt_reg == 9'(DATA_BITS - 1))
                            begin
                                bitcnt_next = 9'd0;
                                phase_next  = PH_RELEASE;
                                if (mode_reg == MODE_CLEAR)
                                begin
                                    board_next = 2'd0;
                                end
                            end
                            else
                            begin
                                bitcnt_next = bitcnt_reg + 9'd1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // frame store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[item.load_address[AW-1:0]] <= item.load_value;
        end
        if (fire && a_fetch)
        begin
            rdata_reg <= store_mem[fetch_idx[AW-1:0]];
        end
    end

    assign byte_sel = b_fetch_reg ? rdata_reg : byte_reg;
    assign b_data   = b_ref_reg ? byte_sel[3'd7 - b_pos_reg] : b_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            phase_reg      <= PH_HEAD;
            board_reg      <= 2'd0;
            bitcnt_reg     <= 9'd0;
            shift_reg      <= 12'd0;
            read_index_reg <= 8'd0;
            sel_reg        <= 4'hF;
            wrap_last_reg  <= WRAP_LAST_RESET;
            b_valid_reg    <= 1'b0;
            b_sel_reg      <= 4'hF;
            b_strobe_reg   <= 1'b0;
            b_bit_reg      <= 1'b0;
            b_busy_reg     <= 1'b0;
            b_done_reg     <= 1'b0;
            b_ref_reg      <= 1'b0;
            b_fetch_reg    <= 1'b0;
            b_pos_reg      <= 3'd0;
            byte_reg       <= 8'd0;
            out_valid_reg  <= 1'b0;
            out_sel_reg    <= 4'hF;
            out_bit_reg    <= 1'b0;
            out_strobe_reg <= 1'b0;
            out_busy_reg   <= 1'b0;
            out_done_reg   <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            board_reg      <= board_next;
            bitcnt_reg     <= bitcnt_next;
            shift_reg      <= shift_next;
            read_index_reg <= read_index_next;
            sel_reg        <= sel_next;
            wrap_last_reg  <= wrap_last_next;
            if (advance)
            begin
                if (b_valid_reg && b_fetch_reg)
                begin
                    byte_reg <= rdata_reg;
                end
                out_valid_reg  <= b_valid_reg;
                out_sel_reg    <= b_sel_reg;
                out_bit_reg    <= b_data;
                out_strobe_reg <= b_strobe_reg;
                out_busy_reg   <= b_busy_reg;
                out_done_reg   <= b_done_reg;
                b_valid_reg    <= fire;
                b_sel_reg      <= sel_next;
                b_strobe_reg   <= a_strobe;
                b_bit_reg      <= a_bit;
                b_busy_reg     <= (mode_next != MODE_IDLE);
                b_done_reg     <= a_done;
                b_ref_reg      <= a_ref;
                b_fetch_reg    <= a_fetch;
                b_pos_reg      <= bitcnt_reg[2:0];
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign chip_selects_n = out_sel_reg;
    assign data_bit       = out_bit_reg;
    assign bit_strobe     = out_strobe_reg;
    assign busy_res       = out_busy_reg;
    assign done_res       = out_done_reg;

endmodule

>>> rtl/led_matrix_serial_frame_writer.sv
// Three-wire writer for up to four LED-matrix driver boards. Every beat gives one
// result beat: loads fill the frame store, starts launch a command, refresh or
// clear, and each tick during an operation clocks one serial bit or releases one
// chip select. One beat is taken per cycle while the output is not stalled; a
// beat's result is presented once it has passed the sequencer and the store read
// stage behind the input queue. The sequencer advances its bit counter and shift
// word once per tick, and the frame store read that a refresh byte needs sits in
// the stage after it, so no tick waits on memory; a start mid-operation is ignored.
// The user must write wrap_last only while no beat is in flight; not enforced.
module led_matrix_serial_frame_writer #(
    parameter int STORE_DEPTH = lmsfw_pkg::STORE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [7:0]  load_address,
    input  logic [7:0]  load_value,
    input  logic [11:0] command_word,
    input  logic [7:0]  start_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  chip_selects_n,
    output logic        data_bit,
    output logic        bit_strobe,
    output logic        busy_res,
    output logic        done_res
);
    import lmsfw_pkg::*;

    logic  item_valid;
    logic  item_pop;
    item_t item;

    lmsfw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .load_address (load_address),
        .load_value   (load_value),
        .command_word (command_word),
        .start_index  (start_index),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop)
    );

    lmsfw_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chip_selects_n (chip_selects_n),
        .data_bit       (data_bit),
        .bit_strobe     (bit_strobe),
        .busy_res       (busy_res),
        .done_res       (done_res)
    );

endmodule

>>> tb/led_matrix_serial_frame_writer_test.sv
`timescale 1ns / 100ps

module led_matrix_serial_frame_writer_test;

    import lmsfw_pkg::*;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int PHASES        = 6;
    localparam int PHASE_QUOTA   = 80;
    localparam int FILL_ENTRIES  = 80;
    localparam int SETTLE_CYCLES = 10;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 21;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_COMMAND, SEQ_REFRESH, SEQ_CLEAR} seq_mode_t;
    typedef enum logic [1:0] {STAGE_HEAD, STAGE_DATA, STAGE_RELEASE} stage_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  load_address;
        logic [7:0]  load_value;
        logic [11:0] command_word;
        logic [7:0]  start_index;
    } beat_t;

    typedef struct packed {
        logic [3:0] cs_n;
        logic       data;
        logic       strobe;
        logic       busy;
        logic       done;
    } line_state_t;

    typedef struct packed {
        beat_t       beat;
        logic        pinned;
        line_state_t lines;
        logic        run_out;
    } directed_row_t;

    localparam line_state_t LINES_IDLE      = '{4'hF, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam line_state_t LINES_ARMED     = '{4'hF, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam line_state_t LINES_FIRST_ONE = '{4'hE, 1'b1, 1'b1, 1'b1, 1'b0};
    localparam line_state_t LINES_HELD      = '{4'hE, 1'b0, 1'b0, 1'b1, 1'b0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [7:0]  cfg_write_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode = OP_TICK;
    logic [7:0]  load_address = 8'h00;
    logic [7:0]  load_value = 8'h00;
    logic [11:0] command_word = 12'h000;
    logic [7:0]  start_index = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  chip_selects_n;
    logic        data_bit;
    logic        bit_strobe;
    logic        busy_res;
    logic        done_res;

    // serializer image
    logic [7:0]  store_img [256];
    seq_mode_t   seq_mode = SEQ_IDLE;
    stage_t      stage = STAGE_HEAD;
    logic [1:0]  board_no = 2'd0;
    logic [8:0]  bit_no = 9'd0;
    logic [11:0] shift_reg = 12'h000;
    logic [7:0]  rd_ptr = 8'h00;
    logic [3:0]  cs_lines = 4'hF;
    logic [7:0]  wrap_reg = WRAP_LAST_RESET;

    line_state_t pending_lines [$];
    logic        pin_active = 1'b0;
    line_state_t pin_value = LINES_IDLE;
    int          fault_count = 0;
    int          sender_gap_pct = 21;
    int          receiver_stall_pct = 84;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{OP_TICK,        8'h00, 8'h00, 12'h000, 8'h00}, 1'b1, LINES_IDLE,      1'b0},
        '{'{OP_SPARE_FIRST, 8'h00, 8'h00, 12'h000, 8'h00}, 1'b1, LINES_IDLE,      1'b0},
        '{'{OP_SPARE_LAST,  8'hFF, 8'hFF, 12'hFFF, 8'hFF}, 1'b1, LINES_IDLE,      1'b0},
        '{'{OP_LOAD,        8'h00, 8'hFF, 12'h000, 8'h00}, 1'b1, LINES_IDLE,      1'b0},
        '{'{OP_LOAD,        8'hFF, 8'h00, 12'hFFF, 8'hFF}, 1'b1, LINES_IDLE,      1'b0},
        '{'{OP_COMMAND,     8'h00, 8'h00, 12'hFFF, 8'h00}, 1'b1, LINES_ARMED,     1'b0},
        '{'{OP_TICK,        8'h00, 8'h00, 12'h000, 8'h00}, 1'b1, LINES_FIRST_ONE, 1'b0},
        '{'{OP_REFRESH,     8'h00, 8'h00, 12'h000, 8'h00}, 1'b1, LINES_HELD,      1'b0},
        '{'{OP_CLEAR,       8'h00, 8'h00, 12'h000, 8'h00}, 1'b1, LINES_HELD,      1'b0},
        '{'{OP_COMMAND,     8'h00, 8'h00, 12'h000, 8'h00}, 1'b1, LINES_HELD,      1'b0},
        '{'{OP_LOAD,        8'h80, 8'hA5, 12'h000, 8'h00}, 1'b1, LINES_HELD,      1'b1},
        '{'{OP_COMMAND,     8'h00, 8'h00, 12'h000, 8'h00}, 1'b1, LINES_ARMED,     1'b1},
        '{'{OP_TICK,        8'h00, 8'h00, 12'h000, 8'h00}, 1'b1, LINES_IDLE,      1'b0},
        '{'{OP_CLEAR,       8'h00, 8'h00, 12'h000, 8'h00}, 1'b1, LINES_ARMED,     1'b0},
        '{'{OP_TICK,        8'h00, 8'h00, 12'h000, 8'h00}, 1'b0, LINES_IDLE,      1'b0},
        '{'{OP_REFRESH,     8'h00, 8'h00, 12'h000, 8'h40}, 1'b1, LINES_HELD,      1'b1},
        '{'{OP_TICK,        8'h00, 8'h00, 12'h000, 8'h00}, 1'b1, LINES_IDLE,      1'b0},
        '{'{OP_REFRESH,     8'h00, 8'h00, 12'h000, 8'hFF}, 1'b1, LINES_ARMED,     1'b0},
        '{'{OP_TICK,        8'h00, 8'h00, 12'h000, 8'h00}, 1'b0, LINES_IDLE,      1'b0},
        '{'{OP_COMMAND,     8'h00, 8'h00, 12'hFFF, 8'h00}, 1'b1, LINES_HELD,      1'b0},
        '{'{OP_LOAD,        8'h00, 8'h3C, 12'h000, 8'h00}, 1'b1, LINES_HELD,      1'b0}
    };

    led_matrix_serial_frame_writer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .load_address   (load_address),
        .load_value     (load_value),
        .command_word   (command_word),
        .start_index    (start_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chip_selects_n (chip_selects_n),
        .data_bit       (data_bit),
        .bit_strobe     (bit_strobe),
        .busy_res       (busy_res),
        .done_res       (done_res)
    );

    always #6 clk = ~clk;

    task automatic advance_serializer(input beat_t b, output line_state_t r);
        logic [3:0] sel;
        logic [7:0] idx;
        int         k;
        r = LINES_IDLE;
        sel = 4'b0001 << board_no;
        case (b.opcode) inside
            OP_LOAD:
                store_img[b.load_address] = b.load_value;
            OP_COMMAND, OP_REFRESH, OP_CLEAR:
                if (seq_mode == SEQ_IDLE)
                begin
                    board_no = 2'd0;
                    bit_no = 9'd0;
                    stage = STAGE_HEAD;
                    shift_reg = 12'h000;
                    if (b.opcode == OP_COMMAND)
                    begin
                        seq_mode = SEQ_COMMAND;
                        shift_reg = b.command_word;
                    end
                    else if (b.opcode == OP_REFRESH)
                    begin
                        seq_mode = SEQ_REFRESH;
                        rd_ptr = b.start_index;
                    end
                    else
                    begin
                        seq_mode = SEQ_CLEAR;
                    end
                end
            OP_TICK:
                if (seq_mode != SEQ_IDLE)
                begin
                    if (stage == STAGE_RELEASE)
                    begin
                        cs_lines = cs_lines | sel;
                        if (int'(board_no) + 1 >= BOARD_COUNT)
                        begin
                            seq_mode = SEQ_IDLE;
                            board_no = 2'd0;
                            bit_no = 9'd0;
                            stage = STAGE_HEAD;
                            r.done = 1'b1;
                        end
                        else
                        begin
                            board_no = board_no + 2'd1;
                            bit_no = 9'd0;
                            stage = (seq_mode == SEQ_CLEAR) ? STAGE_RELEASE : STAGE_HEAD;
                        end
                    end
                    else if (seq_mode == SEQ_COMMAND)
                    begin
                        cs_lines = cs_lines & ~sel;
                        r.strobe = 1'b1;
                        r.data = shift_reg[11];
                        shift_reg = {shift_reg[10:0], shift_reg[11]};
                        bit_no = bit_no + 9'd1;
                        if (int'(bit_no) >= COMMAND_BITS)
                        begin
                            bit_no = 9'd0;
                            stage = STAGE_RELEASE;
                        end
                    end
                    else if (stage == STAGE_HEAD)
                    begin
                        k = int'(bit_no) % PREFIX_BITS;
                        cs_lines = cs_lines & ~sel;
                        r.strobe = 1'b1;
                        r.data = PREFIX_WORD[PREFIX_BITS - 1 - k];
                        bit_no = 9'(k + 1);
                        if (int'(bit_no) >= PREFIX_BITS)
                        begin
                            bit_no = 9'd0;
                            if (seq_mode == SEQ_CLEAR && int'(board_no) + 1 < BOARD_COUNT)
                                board_no = board_no + 2'd1;
                            else
                                stage = STAGE_DATA;
                        end
                    end
                    else
                    begin
                        r.strobe = 1'b1;
                        if (seq_mode == SEQ_REFRESH)
                        begin
                            // byte fetch with wrap back to the start of the store
                            if (bit_no[2:0] == 3'd0)
                            begin
                                idx = rd_ptr;
                                if (idx > wrap_reg || int'(idx) >= STORE_DEPTH_DEF)
                                    idx = 8'h00;
                                rd_ptr = idx + 8'd1;
                                shift_reg = {4'h0, store_img[idx]};
                            end
                            r.data = shift_reg[7];
                            shift_reg = {4'h0, shift_reg[6:0], 1'b0};
                        end
                        if (int'(bit_no) + 1 >= DATA_BITS)
                        begin
                            bit_no = 9'd0;
                            stage = STAGE_RELEASE;
                            if (seq_mode == SEQ_CLEAR)
                                board_no = 2'd0;
                        end
                        else
                        begin
                            bit_no = bit_no + 9'd1;
                        end
                    end
                end
            default:
                ;
        endcase
        r.cs_n = cs_lines;
        r.busy = (seq_mode != SEQ_IDLE);
    endtask

    always @(posedge clk)
    begin : scoreboard
        beat_t       seen;
        line_state_t want;
        line_state_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen = {opcode, load_address, load_value, command_word, start_index};
                advance_serializer(seen, want);
                pending_lines.push_back(pin_active ? pin_value : want);
            end
            if (out_valid && !out_stall)
            begin
                got = '{chip_selects_n, data_bit, bit_strobe, busy_res, done_res};
                if (pending_lines.size() == 0)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display("%0t: unexpected result beat cs_n=%h data=%b strobe=%b",
                                 $time, got.cs_n, got.data, got.strobe);
                    fault_count++;
                end
                else
                begin
                    want = pending_lines.pop_front();
                    if (got.cs_n !== want.cs_n || got.data !== want.data
                        || got.strobe !== want.strobe || got.busy !== want.busy
                        || got.done !== want.done)
                    begin
                        if (fault_count < REPORT_LIMIT)
                        begin
                            $write("%0t: expected cs_n=%h data=%b strobe=%b busy=%b done=%b",
                                   $time, want.cs_n, want.data, want.strobe, want.busy,
                                   want.done);
                            $display(", got cs_n=%h data=%b strobe=%b busy=%b done=%b",
                                     got.cs_n, got.data, got.strobe, got.busy, got.done);
                        end
                        fault_count++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
        out_stall = ($urandom_range(99) < receiver_stall_pct);

    function automatic beat_t random_beat(input logic [2:0] op);
        beat_t b;
        b = {op, 8'($urandom), 8'($urandom), 12'($urandom), 8'($urandom)};
        return b;
    endfunction

    function automatic beat_t noise_beat();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return random_beat(OP_LOAD);
        if (pick < 65)
            return random_beat(OP_TICK);
        if (pick < 90)
            return random_beat(3'($urandom_range(OP_COMMAND, OP_CLEAR)));
        return random_beat(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
    endfunction

    task automatic send_beat(input beat_t b, input logic pin = 1'b0,
                             input line_state_t pinned = LINES_IDLE);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        {opcode, load_address, load_value, command_word, start_index} = b;
        pin_active = pin;
        pin_value = pinned;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic finish_operation();
        while (seq_mode != SEQ_IDLE)
        begin
            if ($urandom_range(99) < 8)
                send_beat(noise_beat());
            else
                send_beat(random_beat(OP_TICK));
        end
    endtask

    task automatic wait_for_results();
        in_valid = 1'b0;
        while (pending_lines.size() != 0)
            @(negedge clk);
    endtask

    task automatic settle_block();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_wrap_last(input logic [7:0] value);
        cfg_write_en = 1'b1;
        cfg_write_data = value;
        @(negedge clk);
        cfg_write_en = 1'b0;
        wrap_reg = value;
    endtask

    task automatic run_random_phase(input int quota);
        int    sent;
        int    pick;
        beat_t b;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(99) == 0)
                wait_for_results();
            pick = $urandom_range(99);
            if (seq_mode != SEQ_IDLE)
                b = (pick < 92) ? random_beat(OP_TICK) : noise_beat();
            else if (pick < 40)
                b = random_beat(OP_COMMAND);
            else if (pick < 65)
                b = random_beat(OP_CLEAR);
            else if (pick < 70)
                b = random_beat(OP_REFRESH);
            else
                b = noise_beat();
            send_beat(b);
            sent++;
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] wrap_plan [PHASES];
        int         gap_plan [3];
        int         stall_plan [3];
        gap_plan = '{21, 84, 0};
        stall_plan = '{84, 21, 0};
        wrap_plan = '{8'hFF, 8'h00, 8'd47, 8'($urandom), 8'hBF, 8'h01};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // low store entries written before the refresh walks through them
        for (int i = 0; i < FILL_ENTRIES; i++)
            send_beat({OP_LOAD, 8'(i), 8'($urandom), 12'($urandom), 8'($urandom)});

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_beat(directed_rows[r].beat, directed_rows[r].pinned, directed_rows[r].lines);
            if (directed_rows[r].run_out)
                finish_operation();
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle_block();
            write_wrap_last(wrap_plan[ph]);
            sender_gap_pct = gap_plan[ph / 2];
            receiver_stall_pct = stall_plan[ph / 2];
            run_random_phase(PHASE_QUOTA);
        end

        settle_block();
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/lmsfw_pkg.sv
rtl/lmsfw_front.sv
rtl/lmsfw_back.sv
rtl/led_matrix_serial_frame_writer.sv
tb/led_matrix_serial_frame_writer_test.sv
